>>> hdl/hsef_pkg.sv
package hsef_pkg;

    // Bead indices at or above this limit raise the fault flag.
    localparam int unsigned BEAD_INDEX_LIMIT = 65536;

    typedef struct packed {
        logic [15:0]        first_bead;
        logic [15:0]        second_bead;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [31:0]        stiffness;
        logic [30:0]        rest_length;
        logic               last_pair;
    } item_t;

    typedef struct packed {
        logic [62:0]        pair_energy;
        logic [62:0]        energy_total;
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic [15:0]        out_first_bead;
        logic [15:0]        out_second_bead;
        logic               fault;
        logic               last_out;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_STRETCH,
        ST_MK,
        ST_ME,
        ST_MN,
        ST_DIVL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

>>> hdl/harmonic_spring_energy_force.sv
// One word at a time: the input stalls until the result is loaded. Coincident
//   points skip the force steps and a force axis that saturates skips its
//   divide. The sequencer shares the single bit-serial shift-add multiplier,
//   restoring square root and restoring divider.
// Reset (rst_n, async, active low): sequencer idle, no result held, energy
//   total and sticky fault cleared.
module harmonic_spring_energy_force #(
    parameter int unsigned BEAD_INDEX_LIMIT = hsef_pkg::BEAD_INDEX_LIMIT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  hsef_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output hsef_pkg::result_t result
);

    // Datapath widths
    localparam int ACC_W = 98;   // as*as*k < 2^98, sum of squares < 2^66
    localparam int M_W   = 65;   // as*k
    localparam int REM_W = 50;   // divider remainder, shifted

    hsef_pkg::state_t state_reg, state_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [1:0]          axis_reg, axis_next;
    logic [62:0]         accum_reg, accum_next;
    logic                fault_seen_reg, fault_seen_next;
    logic                result_valid_reg, result_valid_next;
    hsef_pkg::result_t   result_reg, result_next;

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [32:0]         mplier_reg, mplier_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [33:0]         root_reg, root_next;
    logic [M_W-1:0]      m_reg, m_next;
    logic [32:0]         as_reg, as_next;
    logic                sneg_reg, sneg_next;
    logic [46:0]         q_reg, q_next;
    logic [62:0]         energy_reg, energy_next;
    logic                ifault_reg, ifault_next;
    logic [2:0][31:0]    am_reg, am_next;
    logic [2:0]          dneg_reg, dneg_next;
    logic [2:0][47:0]    force_reg, force_next;
    logic [15:0]         bead1_reg, bead1_next;
    logic [15:0]         bead2_reg, bead2_next;
    logic [31:0]         k_reg, k_next;
    logic [30:0]         r_reg, r_next;
    logic                last_reg, last_next;

    // Shared units
    logic [ACC_W-1:0]    mul_sum;
    logic [37:0]         root_rem, root_trial, root_diff;
    logic                root_ge;
    logic [REM_W-1:0]    div_dv, div_rem, div_diff;
    logic                div_ge, ovf_ge;
    logic [33:0]         s_w;
    logic [46:0]         q_step, force_mag;
    logic                force_neg;
    logic [47:0]         force_val;
    logic [63:0]         tot_w;
    logic [62:0]         tot_sat;
    logic                tot_ovf, fault_out, bead_bad, result_load;
    logic [1:0]          axis_inc;
    logic [2:0][31:0]    coord1, coord2;
    logic [2:0][32:0]    delta_w;

    assign coord1 = {item.first_z, item.first_y, item.first_x};
    assign coord2 = {item.second_z, item.second_y, item.second_x};

    // One multiplier bit per cycle
    assign mul_sum = acc_reg + (mplier_reg[0] ? mcand_reg : {ACC_W{1'b0}});

    // Square root: two radicand bits per cycle from acc[67:66]
    assign root_rem   = {rem_reg[35:0], acc_reg[67:66]};
    assign root_trial = {2'b00, root_reg, 2'b01};
    assign root_ge    = root_rem >= root_trial;
    assign root_diff  = root_rem - root_trial;

    // Divider: divisor is d in Q16.16 shifted up 16
    assign div_dv   = {1'b0, root_reg[32:0], 16'h0000};
    assign div_rem  = {rem_reg[48:0], acc_reg[46]};
    assign div_ge   = div_rem >= div_dv;
    assign div_diff = div_rem - div_dv;
    assign ovf_ge   = acc_reg[96:47] >= div_dv;
    assign q_step   = {q_reg[45:0], div_ge};

    assign s_w = {1'b0, root_reg[32:0]} - {3'b000, r_reg};

    assign force_mag = (state_reg == hsef_pkg::ST_DIV) ? q_step : {47{1'b1}};
    assign force_neg = sneg_reg ^ dneg_reg[axis_reg];
    assign force_val = force_neg ? 48'(-{1'b0, force_mag}) : {1'b0, force_mag};

    assign tot_w     = {1'b0, accum_reg} + {1'b0, energy_reg};
    assign tot_ovf   = tot_w[63];
    assign tot_sat   = tot_ovf ? {63{1'b1}} : tot_w[62:0];
    assign fault_out = fault_seen_reg | ifault_reg | tot_ovf;

    assign bead_bad = (32'(item.first_bead) >= BEAD_INDEX_LIMIT) ||
                      (32'(item.second_bead) >= BEAD_INDEX_LIMIT);

    assign axis_inc    = axis_reg + 2'd1;
    assign result_load = !result_valid_reg || !result_stall;

    assign item_stall   = (state_reg != hsef_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        axis_next         = axis_reg;
        accum_next        = accum_reg;
        fault_seen_next   = fault_seen_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        m_next            = m_reg;
        as_next           = as_reg;
        sneg_next         = sneg_reg;
        q_next            = q_reg;
        energy_next       = energy_reg;
        ifault_next       = ifault_reg;
        am_next           = am_reg;
        dneg_next         = dneg_reg;
        force_next        = force_reg;
        bead1_next        = bead1_reg;
        bead2_next        = bead2_reg;
        k_next            = k_reg;
        r_next            = r_reg;
        last_next         = last_reg;

        for (int i = 0; i < 3; i++)
        begin
            delta_w[i] = {coord1[i][31], coord1[i]} - {coord2[i][31], coord2[i]};
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            hsef_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dneg_next[i] = delta_w[i][32];
                        am_next[i]   = delta_w[i][32] ? 32'(-delta_w[i]) : delta_w[i][31:0];
                    end
                    bead1_next  = item.first_bead;
                    bead2_next  = item.second_bead;
                    k_next      = item.stiffness;
                    r_next      = item.rest_length;
                    last_next   = item.last_pair;
                    ifault_next = bead_bad;
                    acc_next    = '0;
                    mcand_next  = ACC_W'(am_next[0]);
                    mplier_next = {1'b0, am_next[0]};
                    cnt_next    = '0;
                    axis_next   = '0;
                    state_next  = hsef_pkg::ST_SQ;
                end
            end
            hsef_pkg::ST_SQ:
            begin
                // squares of all three axes land in one sum
                acc_next    = mul_sum;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[32:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    cnt_next = '0;
                    if (axis_reg == 2'd2)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        state_next = hsef_pkg::ST_ROOT;
                    end
                    else
                    begin
                        axis_next   = axis_inc;
                        mcand_next  = ACC_W'(am_reg[axis_inc]);
                        mplier_next = {1'b0, am_reg[axis_inc]};
                    end
                end
            end
            hsef_pkg::ST_ROOT:
            begin
                acc_next  = {acc_reg[ACC_W-3:0], 2'b00};
                rem_next  = REM_W'(root_ge ? root_diff : root_rem);
                root_next = {root_reg[32:0], root_ge};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd33)
                begin
                    cnt_next   = '0;
                    state_next = hsef_pkg::ST_STRETCH;
                end
            end
            hsef_pkg::ST_STRETCH:
            begin
                sneg_next   = s_w[33];
                as_next     = s_w[33] ? 33'(-s_w) : s_w[32:0];
                if (root_reg == '0)
                begin
                    ifault_next = 1'b1;
                end
                acc_next    = '0;
                mcand_next  = ACC_W'(as_next);
                mplier_next = {1'b0, k_reg};
                state_next  = hsef_pkg::ST_MK;
            end
            hsef_pkg::ST_MK:
            begin
                acc_next    = mul_sum;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[32:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    cnt_next    = '0;
                    m_next      = mul_sum[M_W-1:0];
                    acc_next    = '0;
                    mcand_next  = ACC_W'(mul_sum[M_W-1:0]);
                    mplier_next = as_reg;
                    state_next  = hsef_pkg::ST_ME;
                end
            end
            hsef_pkg::ST_ME:
            begin
                acc_next    = mul_sum;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[32:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    cnt_next = '0;
                    // energy = (k*s^2) >> 33, saturating at 2^63-1
                    if (mul_sum[97:96] != 2'b00)
                    begin
                        energy_next = {63{1'b1}};
                        ifault_next = 1'b1;
                    end
                    else
                    begin
                        energy_next = mul_sum[95:33];
                    end
                    axis_next = '0;
                    if (root_reg == '0)
                    begin
                        force_next = '0;
                        state_next = hsef_pkg::ST_DONE;
                    end
                    else
                    begin
                        acc_next    = '0;
                        mcand_next  = ACC_W'(m_reg);
                        mplier_next = {1'b0, am_reg[0]};
                        state_next  = hsef_pkg::ST_MN;
                    end
                end
            end
            hsef_pkg::ST_MN:
            begin
                acc_next    = mul_sum;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[32:1]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    cnt_next   = '0;
                    state_next = hsef_pkg::ST_DIVL;
                end
            end
            hsef_pkg::ST_DIVL:
            begin
                // quotient of 2^47 or more saturates without dividing
                if (ovf_ge)
                begin
                    ifault_next          = 1'b1;
                    force_next[axis_reg] = force_val;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = hsef_pkg::ST_DONE;
                    end
                    else
                    begin
                        axis_next   = axis_inc;
                        acc_next    = '0;
                        mcand_next  = ACC_W'(m_reg);
                        mplier_next = {1'b0, am_reg[axis_inc]};
                        state_next  = hsef_pkg::ST_MN;
                    end
                end
                else
                begin
                    rem_next   = acc_reg[96:47];
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = hsef_pkg::ST_DIV;
                end
            end
            hsef_pkg::ST_DIV:
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0};
                rem_next = div_ge ? div_diff : div_rem;
                q_next   = q_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd46)
                begin
                    cnt_next             = '0;
                    force_next[axis_reg] = force_val;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = hsef_pkg::ST_DONE;
                    end
                    else
                    begin
                        axis_next   = axis_inc;
                        acc_next    = '0;
                        mcand_next  = ACC_W'(m_reg);
                        mplier_next = {1'b0, am_reg[axis_inc]};
                        state_next  = hsef_pkg::ST_MN;
                    end
                end
            end
            hsef_pkg::ST_DONE:
            begin
                if (result_load)
                begin
                    result_valid_next           = 1'b1;
                    result_next.pair_energy     = energy_reg;
                    result_next.energy_total    = tot_sat;
                    result_next.force_x         = force_reg[0];
                    result_next.force_y         = force_reg[1];
                    result_next.force_z         = force_reg[2];
                    result_next.out_first_bead  = bead1_reg;
                    result_next.out_second_bead = bead2_reg;
                    result_next.fault           = fault_out;
                    result_next.last_out        = last_reg;
                    // end of set clears the running total and sticky fault
                    if (last_reg)
                    begin
                        accum_next      = '0;
                        fault_seen_next = 1'b0;
                    end
                    else
                    begin
                        accum_next      = tot_sat;
                        fault_seen_next = fault_out;
                    end
                    state_next = hsef_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hsef_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hsef_pkg::ST_IDLE;
            cnt_reg          <= '0;
            axis_reg         <= '0;
            accum_reg        <= '0;
            fault_seen_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            axis_reg         <= axis_next;
            accum_reg        <= accum_next;
            fault_seen_reg   <= fault_seen_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        m_reg      <= m_next;
        as_reg     <= as_next;
        sneg_reg   <= sneg_next;
        q_reg      <= q_next;
        energy_reg <= energy_next;
        ifault_reg <= ifault_next;
        am_reg     <= am_next;
        dneg_reg   <= dneg_next;
        force_reg  <= force_next;
        bead1_reg  <= bead1_next;
        bead2_reg  <= bead2_next;
        k_reg      <= k_next;
        r_reg      <= r_next;
        last_reg   <= last_next;
    end

    // a new result only ever comes out of the final state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == hsef_pkg::ST_DONE))
        else $error("result raised outside final state");

    // divider never runs past 47 quotient bits
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsef_pkg::ST_DIV) |-> (cnt_reg < 6'd47))
        else $error("divider step count out of range");

    // without a fault the total holds at least this word's energy
    a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.fault) |-> (result.energy_total >= result.pair_energy))
        else $error("energy total below pair energy without fault");

endmodule

>>> tb/hsef_checker.sv
module hsef_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  hsef_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  hsef_pkg::result_t result,
    output int unsigned       fail_count,
    output int unsigned       pending
);

    localparam logic [63:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FORCE_MAX  = 64'h0000_7FFF_FFFF_FFFF;

    hsef_pkg::result_t expected_words[$];
    logic [62:0]       energy_sum;
    logic              fault_sticky;

    // floor(sqrt(v)) for v below 2^68
    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0]  root;
        logic [127:0] rem;
        logic [127:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 33; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = {root, 2'b01};
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end
            else
                root = {root[62:0], 1'b0};
        end
        return root;
    endfunction

    // Predicts one result word and advances the set totals.
    function automatic hsef_pkg::result_t spring_response(input hsef_pkg::item_t w);
        hsef_pkg::result_t r;
        longint       delta[3];
        logic [63:0]  span[3];
        logic [127:0] dist_sq;
        logic [63:0]  span_len;
        longint       stretch;
        logic [63:0]  stretch_mag;
        logic [127:0] prod;
        logic [63:0]  energy;
        logic [64:0]  total;
        logic [127:0] quot;
        logic [63:0]  fmag;
        logic         bad;
        bad = 1'b0;
        delta[0] = longint'($signed(w.first_x)) - longint'($signed(w.second_x));
        delta[1] = longint'($signed(w.first_y)) - longint'($signed(w.second_y));
        delta[2] = longint'($signed(w.first_z)) - longint'($signed(w.second_z));
        dist_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            span[i] = (delta[i] < 0) ? 64'(-delta[i]) : 64'(delta[i]);
            dist_sq += 128'(span[i]) * 128'(span[i]);
        end
        span_len    = root_floor(dist_sq);
        stretch     = longint'(span_len) - longint'({33'd0, w.rest_length});
        stretch_mag = (stretch < 0) ? 64'(-stretch) : 64'(stretch);

        prod = 128'(stretch_mag) * 128'(stretch_mag) * 128'(w.stiffness);
        if (prod >= (128'd1 << 96))
        begin
            energy = ENERGY_MAX;
            bad    = 1'b1;
        end
        else
            energy = 64'(prod >> 33);

        total = 65'(energy_sum) + 65'(energy);
        if (total > 65'(ENERGY_MAX))
        begin
            total = 65'(ENERGY_MAX);
            bad   = 1'b1;
        end

        if (32'(w.first_bead) >= hsef_pkg::BEAD_INDEX_LIMIT ||
            32'(w.second_bead) >= hsef_pkg::BEAD_INDEX_LIMIT)
            bad = 1'b1;

        r.force_x = '0;
        r.force_y = '0;
        r.force_z = '0;
        if (span_len == 0)
            bad = 1'b1;
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                quot = (128'(stretch_mag) * 128'(span[i]) * 128'(w.stiffness))
                     / (128'(span_len) << 16);
                if (quot > 128'(FORCE_MAX))
                begin
                    fmag = FORCE_MAX;
                    bad  = 1'b1;
                end
                else
                    fmag = 64'(quot);
                if ((stretch < 0) != (delta[i] < 0))
                    fmag = -fmag;
                case (i)
                    0: r.force_x = fmag[47:0];
                    1: r.force_y = fmag[47:0];
                    default: r.force_z = fmag[47:0];
                endcase
            end
        end

        fault_sticky      = fault_sticky | bad;
        r.pair_energy     = energy[62:0];
        r.energy_total    = total[62:0];
        r.out_first_bead  = w.first_bead;
        r.out_second_bead = w.second_bead;
        r.fault           = fault_sticky;
        r.last_out        = w.last_pair;
        if (w.last_pair)
        begin
            energy_sum   = '0;
            fault_sticky = 1'b0;
        end
        else
            energy_sum = total[62:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsef_pkg::result_t want;
        if (!rst_n)
        begin
            energy_sum   = '0;
            fault_sticky = 1'b0;
            fail_count   <= 0;
            pending      <= 0;
            expected_words.delete();
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_words.push_back(spring_response(item));
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (result.pair_energy !== want.pair_energy)
                            $error("pair_energy exp %0h got %0h", want.pair_energy,
                                   result.pair_energy);
                        if (result.energy_total !== want.energy_total)
                            $error("energy_total exp %0h got %0h", want.energy_total,
                                   result.energy_total);
                        if (result.force_x !== want.force_x)
                            $error("force_x exp %0h got %0h", want.force_x, result.force_x);
                        if (result.force_y !== want.force_y)
                            $error("force_y exp %0h got %0h", want.force_y, result.force_y);
                        if (result.force_z !== want.force_z)
                            $error("force_z exp %0h got %0h", want.force_z, result.force_z);
                        if (result.out_first_bead !== want.out_first_bead)
                            $error("out_first_bead exp %0h got %0h", want.out_first_bead,
                                   result.out_first_bead);
                        if (result.out_second_bead !== want.out_second_bead)
                            $error("out_second_bead exp %0h got %0h", want.out_second_bead,
                                   result.out_second_bead);
                        if (result.fault !== want.fault)
                            $error("fault exp %0b got %0b", want.fault, result.fault);
                        if (result.last_out !== want.last_out)
                            $error("last_out exp %0b got %0b", want.last_out, result.last_out);
                    end
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

>>> tb/tb_harmonic_spring_energy_force.sv
module tb_harmonic_spring_energy_force;

    // One spring per word; the cap covers 600 words plus long stalls several
    // times over.
    localparam int unsigned RANDOM_WORDS = 600;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned DRAIN_CYCLES = 1000;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    hsef_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    hsef_pkg::result_t result;
    int unsigned       fail_count;
    int unsigned       pending;
    int unsigned       cycle_count = 0;
    logic              hold_req;
    logic              hold_done;

    harmonic_spring_energy_force dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    hsef_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle length: mostly zero or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(4, 1);
        return $urandom_range(200, 20);
    endfunction

    // Receiver: random stall runs, plus one long hold-off on request so the
    // block fills and backs up its input.
    initial
    begin
        int unsigned run;
        result_stall = 1'b0;
        hold_done    = 1'b0;
        run          = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                result_stall <= 1'b0;
            end
            else if (run > 0)
                run--;
            else
            begin
                run = idle_len();
                result_stall <= (run != 0);
            end
        end
    end

    task automatic send_word(input hsef_pkg::item_t w, input int unsigned gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Point pair with a chosen spread: full range, near each other, or
    // coincident.
    function automatic hsef_pkg::item_t spring_word(input int unsigned shape,
                                                    input logic last);
        hsef_pkg::item_t w;
        int    spread;
        w.first_bead  = 16'($urandom);
        w.second_bead = 16'($urandom);
        w.first_x     = $urandom;
        w.first_y     = $urandom;
        w.first_z     = $urandom;
        spread        = 1 << $urandom_range(24, 4);
        case (shape)
            0:
            begin
                w.second_x = $urandom;
                w.second_y = $urandom;
                w.second_z = $urandom;
            end
            1:
            begin
                w.second_x = w.first_x + $signed($urandom_range(2 * spread)) - spread;
                w.second_y = w.first_y + $signed($urandom_range(2 * spread)) - spread;
                w.second_z = w.first_z + $signed($urandom_range(2 * spread)) - spread;
            end
            default:
            begin
                w.second_x = w.first_x;
                w.second_y = w.first_y;
                w.second_z = w.first_z;
            end
        endcase
        w.stiffness   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20);
        w.rest_length = ($urandom_range(3) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(1 << 22));
        w.last_pair   = last;
        return w;
    endfunction

    function automatic hsef_pkg::item_t fixed_word(input int fx, input int sx,
                                                   input logic [31:0] k,
                                                   input logic [30:0] rest,
                                                   input logic last);
        hsef_pkg::item_t w;
        w.first_bead  = 16'hFFFF;
        w.second_bead = 16'h0000;
        w.first_x     = fx;
        w.first_y     = fx;
        w.first_z     = fx;
        w.second_x    = sx;
        w.second_y    = sx;
        w.second_z    = sx;
        w.stiffness   = k;
        w.rest_length = rest;
        w.last_pair   = last;
        return w;
    endfunction

    initial
    begin
        hsef_pkg::item_t w;
        hold_req    = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        rst_n       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unit stretch, extremes of coordinates and constants,
        // coincident points, energy and total saturation, set clear.
        send_word(fixed_word(32'h0001_0000, 0, 32'h0001_0000, 31'h0, 1'b0), 0);
        send_word(fixed_word(0, 32'h0001_0000, 32'h0001_0000, 31'h0003_0000, 1'b1), 0);
        send_word(fixed_word(5, 5, 32'h0002_0000, 31'h0001_0000, 1'b0), 0);
        send_word(fixed_word(5, 5, 32'h0, 31'h0, 1'b1), 1);
        send_word(fixed_word(32'h0, 32'h0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0), 0);
        send_word(fixed_word(32'h0, 32'h0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0), 0);
        send_word(fixed_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h0, 1'b1), 2);
        send_word(fixed_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF, 1'b0), 0);
        send_word(fixed_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 31'h0, 1'b1), 0);
        send_word(fixed_word(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 31'h0, 1'b0), 0);
        send_word(fixed_word(1, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1), 0);
        send_word(fixed_word(32'hFFFF_FFFF, 0, 32'h0001_0000, 31'h0000_0001, 1'b0), 3);
        send_word(fixed_word(32'h0000_4000, 0, 32'h0100_0000, 31'h0010_0000, 1'b1), 0);
        w = spring_word(1, 1'b0);
        w.first_bead  = 16'h0000;
        w.second_bead = 16'hFFFF;
        send_word(w, 0);
        send_word(spring_word(2, 1'b1), 0);

        // Random sets of springs, each word ending its set with one chance in eight, mostly near-neighbor pairs.
        for (int unsigned n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
                hold_req = 1'b1;
            if (n == 2 * RANDOM_WORDS / 3)
            begin
                // quiet the sender until the block has drained
                item_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            send_word(spring_word(($urandom_range(9) < 6) ? 1 :
                                  ($urandom_range(4) == 0) ? 2 : 0,
                                  ($urandom_range(7) == 0)),
                      idle_len());
        end
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
